// ----- src/sliding_window_min_max_mean_assert.svh -----
// Assertion helpers for the sliding window statistics block.
`ifndef SLIDING_WINDOW_MIN_MAX_MEAN_ASSERT_SVH
`define SLIDING_WINDOW_MIN_MAX_MEAN_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define SWMMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define SWMMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/swmmm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package swmmm_pkg;

  localparam int unsigned SampleW   = 24;
  localparam int unsigned CountOutW = 7;
  localparam int unsigned QDepth    = 2;

  typedef logic [SampleW-1:0] sample_t;

  // divider result: done pulse plus truncated quotient
  typedef struct packed {
    logic    done;
    sample_t quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- src/swmmm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module swmmm_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- src/swmmm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

// front end: takes words from the input channel into a two-entry queue
module swmmm_queue import swmmm_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire sample_t in_sample_i,
  output logic         in_stall_o,
  input  wire logic    pop_i,
  output logic         valid_o,
  output sample_t      sample_o
);

  localparam int unsigned PtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned FillW = $clog2(QDepth + 1);

  sample_t             mem_q [QDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic                push, pop;

  assign in_stall_o = (fill_q == FillW'(QDepth));
  assign valid_o    = (fill_q != '0);
  assign sample_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_sample_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/swmmm_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module swmmm_div import swmmm_pkg::*; #(
  parameter int unsigned NumW = 31,
  parameter int unsigned DenW = 7
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output div_rsp_t             rsp_o
);

  localparam int unsigned IterW = $clog2(NumW + 1);

  logic [NumW-1:0]  dvd_q;
  logic [DenW-1:0]  rem_q;
  logic [DenW-1:0]  den_q;
  logic [IterW-1:0] iter_q;
  logic             busy_q;
  logic             done_q;
  logic [DenW:0]    rem_sh;
  logic [DenW:0]    rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[NumW-1]};
    ge      = (rem_sh >= {1'b0, den_q});
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= IterW'(NumW);
      end else if (busy_q) begin
        iter_q <= iter_q - 1'b1;
        if (iter_q == IterW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[NumW-2:0], ge};
      rem_q <= ge ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q[SampleW-1:0];

endmodule

`default_nettype wire

// ----- src/swmmm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

// back end: store word, scan held entries, divide, present result
module swmmm_back import swmmm_pkg::*; #(
  parameter int unsigned WindowSize = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_valid_i,
  input  wire sample_t              q_sample_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output sample_t                   min_o,
  output sample_t                   max_o,
  output sample_t                   mean_o,
  output logic [CountOutW-1:0]      count_o
);

  localparam int unsigned IdxW = (WindowSize > 1) ? $clog2(WindowSize) : 1;
  localparam int unsigned CntW = $clog2(WindowSize + 1);
  localparam int unsigned SumW = SampleW + CntW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_START,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                 state_q, state_d;
  logic [IdxW-1:0]        wpos_q, wpos_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [IdxW-1:0]        rd_idx_q, rd_idx_d;
  logic                   rd_pend_q, rd_pend_d;
  sample_t                min_q, min_d;
  sample_t                max_q, max_d;
  logic [SumW-1:0]        sum_q, sum_d;
  sample_t                mean_q, mean_d;
  logic                   out_vld_q, out_vld_d;
  sample_t                out_min_q, out_min_d;
  sample_t                out_max_q, out_max_d;
  sample_t                out_mean_q, out_mean_d;
  logic [CountOutW-1:0]   out_cnt_q, out_cnt_d;

  logic                   ram_we;
  sample_t                ram_rdata;
  div_rsp_t               div_rsp;

  swmmm_ram #(
    .Width (SampleW),
    .Depth (WindowSize)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wpos_q),
    .wdata_i (q_sample_i),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  swmmm_div #(
    .NumW (SumW),
    .DenW (CntW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_START),
    .num_i   (sum_q),
    .den_i   (cnt_q),
    .rsp_o   (div_rsp)
  );

  always_comb begin
    state_d    = state_q;
    wpos_d     = wpos_q;
    cnt_d      = cnt_q;
    rd_idx_d   = rd_idx_q;
    rd_pend_d  = 1'b0;
    min_d      = min_q;
    max_d      = max_q;
    sum_d      = sum_q;
    mean_d     = mean_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_min_d  = out_min_q;
    out_max_d  = out_max_q;
    out_mean_d = out_mean_q;
    out_cnt_d  = out_cnt_q;
    ram_we     = 1'b0;
    q_pop_o    = 1'b0;

    // read data lands in the cycle after its address
    if (rd_pend_q) begin
      if (ram_rdata < min_q) min_d = ram_rdata;
      if (ram_rdata > max_q) max_d = ram_rdata;
      sum_d = sum_q + SumW'(ram_rdata);
    end

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          ram_we   = 1'b1;
          wpos_d   = (wpos_q == IdxW'(WindowSize - 1)) ? '0 : wpos_q + 1'b1;
          cnt_d    = (cnt_q == CntW'(WindowSize)) ? cnt_q : cnt_q + 1'b1;
          rd_idx_d = '0;
          min_d    = '1;
          max_d    = '0;
          sum_d    = '0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_pend_d = 1'b1;
        if (CntW'(rd_idx_q) == cnt_q - 1'b1) begin
          state_d = ST_DRAIN;
        end else begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          mean_d  = div_rsp.quot;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d  = 1'b1;
          out_min_d  = min_q;
          out_max_d  = max_q;
          out_mean_d = mean_q;
          out_cnt_d  = CountOutW'(cnt_q);
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wpos_q     <= '0;
      cnt_q      <= '0;
      rd_idx_q   <= '0;
      rd_pend_q  <= 1'b0;
      min_q      <= '0;
      max_q      <= '0;
      sum_q      <= '0;
      mean_q     <= '0;
      out_vld_q  <= 1'b0;
      out_min_q  <= '0;
      out_max_q  <= '0;
      out_mean_q <= '0;
      out_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      wpos_q     <= wpos_d;
      cnt_q      <= cnt_d;
      rd_idx_q   <= rd_idx_d;
      rd_pend_q  <= rd_pend_d;
      min_q      <= min_d;
      max_q      <= max_d;
      sum_q      <= sum_d;
      mean_q     <= mean_d;
      out_vld_q  <= out_vld_d;
      out_min_q  <= out_min_d;
      out_max_q  <= out_max_d;
      out_mean_q <= out_mean_d;
      out_cnt_q  <= out_cnt_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign min_o       = out_min_q;
  assign max_o       = out_max_q;
  assign mean_o      = out_mean_q;
  assign count_o     = out_cnt_q;

endmodule

`default_nettype wire

// ----- src/sliding_window_min_max_mean.sv -----
// Sliding-window latency statistics. Every input word is one 24-bit
// unsigned latency sample; it goes into a ring of WINDOW_SIZE entries and
// the block returns one result word with the minimum, maximum and truncated
// mean of all samples held so far, plus the number held (saturating at
// WINDOW_SIZE, shown modulo 128 on the 7-bit filled_count). A two-word queue
// takes input while the back end works, and the result sits in an output
// register; a stalled result holds the back end, so the queue then fills and
// stalls the input. The back end handles one word at a time and takes no new
// word until its result is in the output register. The time per word is set
// by the scan of held entries through the single read port of the sample RAM
// plus the one-bit-per-cycle divider.
// No clearing pass after reset: entries are read only after being written.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_min_max_mean import swmmm_pkg::*; #(
  parameter int unsigned WINDOW_SIZE = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire sample_t              latency_sample_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output sample_t                   min_latency_o,
  output sample_t                   max_latency_o,
  output sample_t                   mean_latency_o,
  output logic [CountOutW-1:0]      filled_count_o
);

  // queue -> back end
  logic    q_valid;
  logic    q_pop;
  sample_t q_sample;

  // front: buffers incoming words
  swmmm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_sample_i (latency_sample_i),
    .in_stall_o  (in_stall_o),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .sample_o    (q_sample)
  );

  // back: ring write, scan for min/max/sum, divide, result register
  swmmm_back #(
    .WindowSize (WINDOW_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_sample_i  (q_sample),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .min_o       (min_latency_o),
    .max_o       (max_latency_o),
    .mean_o      (mean_latency_o),
    .count_o     (filled_count_o)
  );

`include "sliding_window_min_max_mean_assert.svh"

  // mean of the held samples always lies between their min and max
  `SWMMM_ASSERT_NOW(a_mean_ge_min, out_valid_o, min_latency_o <= mean_latency_o, "mean below min")
  `SWMMM_ASSERT_NOW(a_mean_le_max, out_valid_o, mean_latency_o <= max_latency_o, "mean above max")
  // back end only takes from the queue when it holds a word
  `SWMMM_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid, "pop from empty queue")
  // a pop starts a scan, so no second pop the next cycle
  `SWMMM_ASSERT_NEXT(a_pop_single, q_pop, !q_pop, "back-to-back pops")

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import swmmm_pkg::*;

  localparam int unsigned WIN       = 64;
  // Idling schedule switches on the count of accepted input words.
  localparam int unsigned PHASE_LEN = 135;
  // Receiver hold-off: starts once this many words went in, lasts this long.
  localparam int unsigned HOLD_AT   = 40;
  localparam int unsigned HOLD_LEN  = 800;
  // Tail wait after the last result.
  localparam int unsigned TAIL_CYC  = 300;

  typedef struct {
    sample_t                lo;
    sample_t                hi;
    sample_t                avg;
    logic [CountOutW-1:0]   cnt;
  } window_stats_t;

  // drain_first: the sender waits for every outstanding result before this word
  typedef struct {
    sample_t value;
    bit      drain_first;
  } pending_word_t;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid    = 1'b0;
  sample_t              in_sample   = '0;
  logic                 out_stall   = 1'b1;
  logic                 in_stall_o;
  logic                 out_valid_o;
  sample_t              min_latency_o;
  sample_t              max_latency_o;
  sample_t              mean_latency_o;
  logic [CountOutW-1:0] filled_count_o;

  pending_word_t  sample_q[$];   // words not yet offered
  window_stats_t  stats_q[$];    // results owed by the block, oldest first
  int unsigned    words_in  = 0;
  int unsigned    errors    = 0;
  int unsigned    hold_left = 0;
  bit             hold_done = 1'b0;

  // Shadow of the block: ring of samples, write pointer, fill count.
  sample_t        ring [WIN];
  int unsigned    wr_pos = 0;
  int unsigned    held   = 0;

  sliding_window_min_max_mean #(
    .WINDOW_SIZE (WIN)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .latency_sample_i (in_sample),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .min_latency_o    (min_latency_o),
    .max_latency_o    (max_latency_o),
    .mean_latency_o   (mean_latency_o),
    .filled_count_o   (filled_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Store one sample and scan entries 0 .. held-1. Only written entries
  // are ever scanned, since held never exceeds the number of writes.
  function automatic window_stats_t push_sample(sample_t s);
    window_stats_t    r;
    longint unsigned  sum;
    int unsigned      i;
    ring[wr_pos] = s;
    wr_pos = (wr_pos + 1 == WIN) ? 0 : wr_pos + 1;
    if (held < WIN) held++;
    sum  = 0;
    r.lo = '1;
    r.hi = '0;
    for (i = 0; i < held; i++) begin
      sum += ring[i];
      if (ring[i] < r.lo) r.lo = ring[i];
      if (ring[i] > r.hi) r.hi = ring[i];
    end
    // mean of 24-bit samples always fits in 24 bits
    r.avg = sample_t'(sum / held);
    r.cnt = held[CountOutW-1:0];
    return r;
  endfunction

  task automatic add_word(sample_t v);
    pending_word_t w;
    w.value = v;
    // two points where the sender lets the pipe run dry first
    w.drain_first = (sample_q.size() == 200) || (sample_q.size() == 320);
    sample_q.push_back(w);
  endtask

  // Sender: holds a word steady until accepted, then may idle before the next one.
  always @(posedge clk_i) begin : drive
    logic        nxt_valid;
    sample_t     nxt_data;
    int unsigned pct;
    nxt_valid = in_valid;
    nxt_data  = in_sample;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        stats_q.push_back(push_sample(in_sample));
        words_in++;
        nxt_valid = 1'b0;
      end
      pct = (words_in < PHASE_LEN) ? 26 : (words_in < 2 * PHASE_LEN) ? 72 : 0;
      if (!nxt_valid && sample_q.size() != 0) begin
        if (!(sample_q[0].drain_first && stats_q.size() != 0) &&
            $urandom_range(99) >= pct) begin
          nxt_valid = 1'b1;
          nxt_data  = sample_q.pop_front().value;
        end
      end
    end
    in_valid  <= nxt_valid;
    in_sample <= nxt_data;
  end

  // Long receiver hold-off, so the input queue fills and the block
  // pushes back on the sender.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && words_in >= HOLD_AT) begin
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  task automatic check_field(string name, logic [SampleW-1:0] want, logic [SampleW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Receiver: compares each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin : check
    window_stats_t want;
    int unsigned   pct;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (stats_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual min %0h max %0h mean %0h cnt %0d",
                 $time, min_latency_o, max_latency_o, mean_latency_o, filled_count_o);
        errors++;
      end else begin
        want = stats_q.pop_front();
        check_field("min_latency", want.lo, min_latency_o);
        check_field("max_latency", want.hi, max_latency_o);
        check_field("mean_latency", want.avg, mean_latency_o);
        check_field("filled_count", SampleW'(want.cnt), SampleW'(filled_count_o));
      end
    end
    pct = (words_in < PHASE_LEN) ? 72 : (words_in < 2 * PHASE_LEN) ? 26 : 0;
    out_stall <= (hold_left != 0) || ($urandom_range(99) < pct);
  end

  initial begin : stimulus
    int unsigned style;
    int unsigned len;
    int unsigned i;
    sample_t     v;
    // directed: field extremes, bit patterns, min/max moving in and out
    add_word(24'h000000);
    add_word(24'hFFFFFF);
    add_word(24'h000001);
    add_word(24'hFFFFFE);
    add_word(24'hAAAAAA);
    add_word(24'h555555);
    add_word(24'h800000);
    add_word(24'h7FFFFF);
    add_word(24'h000000);
    add_word(24'hFFFFFF);
    add_word(24'hF0F0F0);
    add_word(24'h0F0F0F);
    add_word(24'h123456);
    // random segments: full-range noise plus runs of extremes long enough
    // to fill the window (all-max checks the widest sum)
    while (sample_q.size() < 400) begin
      style = $urandom_range(9);
      len   = (style < 2) ? $urandom_range(80, 1) : $urandom_range(40, 1);
      for (i = 0; i < len && sample_q.size() < 400; i++) begin
        case (style)
          0:       v = 24'hFFFFFF;
          1:       v = 24'h000000;
          2:       v = sample_t'($urandom_range(24'hFFFFFF, 24'hFFFF00));
          3:       v = sample_t'($urandom_range(15));
          default: v = sample_t'($urandom);
        endcase
        add_word(v);
      end
    end
    while (sample_q.size() != 0 || in_valid) @(posedge clk_i);
    while (stats_q.size() != 0) @(posedge clk_i);
    // stray words after the last expected one would be caught meanwhile
    repeat (TAIL_CYC) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog: reports a failure and ends a run that hangs
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
